[hw/rtl/auth_rl_pkg.sv]
// Types and constants shared by the authentication failure rate limiter.
package auth_rl_pkg;

  localparam int unsigned SOURCES = 8;
  localparam int unsigned SLOT_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int unsigned KEY_W = 64;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned FAIL_W = 16;
  localparam int unsigned MS_W = 27;
  localparam int unsigned RETRY_W = 17;

  localparam logic [1:0] OP_QUERY = 2'd0;
  localparam logic [1:0] OP_FAIL = 2'd1;
  localparam logic [1:0] OP_OK = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;

  localparam logic [2:0] REG_FREE_TRIES = 3'd0;
  localparam logic [2:0] REG_FIRST_DELAY = 3'd1;
  localparam logic [2:0] REG_MAX_DELAY = 3'd2;
  localparam logic [2:0] REG_BUCKET_SIZE = 3'd3;
  localparam logic [2:0] REG_REFILL_PERIOD = 3'd4;
  localparam logic [2:0] REG_FORGET_AFTER = 3'd5;

  localparam logic [FAIL_W-1:0] FAIL_MAX = 16'hFFFF;
  localparam logic [RETRY_W-1:0] RETRY_MAX = 17'd86400;
  localparam logic [TIME_W-1:0] RETRY_MAX_MS = 48'd86400000;
  localparam logic [MS_W-1:0] ROUND_UP = 27'd999;
  localparam logic [27:0] RECIP_1000 = 28'd137438954;
  localparam int unsigned RECIP_SHIFT = 37;

  typedef struct packed {
    logic vld;
    logic [KEY_W-1:0] key;
    logic hit;
    logic [SLOT_W-1:0] idx;
    logic [SLOT_W-1:0] pick;
    logic pick_vld;
    logic [TIME_W-1:0] pick_ls;
    logic [FAIL_W-1:0] fails;
    logic [TIME_W-1:0] wait_until;
    logic [TIME_W-1:0] last;
    logic told;
  } probe_t;

  typedef struct packed {
    logic en;
    logic [SLOT_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic [FAIL_W-1:0] fails;
    logic [TIME_W-1:0] wait_until;
    logic [TIME_W-1:0] last;
    logic told;
  } slot_wr_t;

endpackage

[hw/rtl/auth_rl_cell.sv]
// One source slot of the table, passing the lookup probe to its neighbor.
module auth_rl_cell import auth_rl_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  probe_t   probe_in,
  output probe_t   probe_out,
  input  slot_wr_t wr
);

  logic valid_r;
  logic [KEY_W-1:0] key_r;
  logic [FAIL_W-1:0] fails_r;
  logic [TIME_W-1:0] wait_r;
  logic [TIME_W-1:0] last_r;
  logic told_r;
  probe_t probe_r;
  probe_t probe_nxt;
  logic wr_sel;

  assign wr_sel = wr.en && (wr.idx == SLOT_W'(IDX));

  always_comb begin
    probe_nxt = probe_in;
    if (!probe_in.hit) begin
      if (valid_r && key_r == probe_in.key) begin
        probe_nxt.hit = 1'b1;
        probe_nxt.idx = SLOT_W'(IDX);
        probe_nxt.fails = fails_r;
        probe_nxt.wait_until = wait_r;
        probe_nxt.last = last_r;
        probe_nxt.told = told_r;
      end else if (!valid_r) begin
        probe_nxt.pick = SLOT_W'(IDX);
        probe_nxt.pick_vld = 1'b0;
      end else if (probe_in.pick_vld && last_r < probe_in.pick_ls) begin
        probe_nxt.pick = SLOT_W'(IDX);
        probe_nxt.pick_ls = last_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      key_r <= wr.key;
      fails_r <= wr.fails;
      wait_r <= wr.wait_until;
      last_r <= wr.last;
      told_r <= wr.told;
    end
    if (!rst_n) begin
      probe_r <= '0;
      valid_r <= 1'b0;
    end else begin
      probe_r <= probe_nxt;
      if (wr_sel) begin
        valid_r <= 1'b1;
      end
    end
  end

  assign probe_out = probe_r;

endmodule

[hw/rtl/auth_failure_rate_limiter_core.sv]
// Top level of the authentication failure rate limiter with its request sequencer.
//
// Channel   Handshake              Payload
// in_       in_valid / in_ready    in_opcode, in_source_key, in_now_ms
// out_      out_valid / out_ready  out_allowed, out_retry_seconds, out_first_refusal
// cfg_      cfg_we                 cfg_index, cfg_wdata
//
// A success or failure request waits in the scan step while the probe walks the row
// of slot cells; a failure past the free tries then doubles the delay in the backoff step.
// A query also scans, then regains tokens in the refill step (up to bucket_size) or
// computes the retry time in the multiply and quotient steps. An unused opcode skips the scan.
// Reset is synchronous and needs no clearing pass.
// A new request is taken while the previous result waits; the last step stalls
// until the output register is free.
module auth_failure_rate_limiter_core import auth_rl_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_opcode,
  input  logic [KEY_W-1:0]    in_source_key,
  input  logic [TIME_W-1:0]   in_now_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_allowed,
  output logic [RETRY_W-1:0]  out_retry_seconds,
  output logic                out_first_refusal,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [MS_W-1:0]     cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_MUL = 3'd3;
  localparam logic [2:0] S_QUOT = 3'd4;
  localparam logic [2:0] S_REFILL = 3'd5;
  localparam logic [2:0] S_BACKOFF = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [7:0] free_r;
  logic [MS_W-1:0] first_r;
  logic [MS_W-1:0] max_r;
  logic [7:0] bucket_r;
  logic [MS_W-1:0] period_r;
  logic [MS_W-1:0] forget_r;

  logic [2:0] state_r;
  logic [1:0] op_r;
  logic [KEY_W-1:0] key_r;
  logic [TIME_W-1:0] now_r;
  logic [SLOT_W-1:0] idx_r;
  logic [FAIL_W-1:0] fails_r;
  logic [TIME_W-1:0] wait_r;
  logic [TIME_W-1:0] last_r;
  logic told_r;
  logic wb_r;
  logic [7:0] tokens_r;
  logic [TIME_W-1:0] anchor_r;
  logic [MS_W:0] dbl_r;
  logic [FAIL_W-1:0] cnt_r;
  logic [MS_W-1:0] x_r;
  logic [54:0] prod_r;
  logic [54:0] prod_nxt;
  logic res_allowed_r;
  logic [RETRY_W-1:0] res_retry_r;
  logic res_first_r;
  logic out_valid_r;
  logic out_allowed_r;
  logic [RETRY_W-1:0] out_retry_r;
  logic out_first_r;

  probe_t chain [SOURCES+1];
  probe_t launch;
  probe_t tail;
  slot_wr_t wr;

  logic [TIME_W:0] quiet;
  logic forget_hit;
  logic [TIME_W-1:0] wdiff;
  logic [TIME_W:0] gap;
  logic due;
  logic [FAIL_W-1:0] fails_inc;
  logic [MS_W-1:0] wait_cl;
  logic [TIME_W:0] end_sum;
  logic [TIME_W-1:0] wait_end;
  logic dbl_go;
  logic out_free;

  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    launch = '0;
    launch.vld = in_valid && in_ready && (in_opcode != OP_NOP);
    launch.key = in_source_key;
    launch.pick_vld = 1'b1;
    launch.pick_ls = '1;
  end

  assign chain[0] = launch;

  for (genvar g = 0; g < SOURCES; g++) begin : g_cell
    auth_rl_cell #(.IDX(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .probe_in  (chain[g]),
      .probe_out (chain[g+1]),
      .wr        (wr)
    );
  end

  assign tail = chain[SOURCES];

  always_comb begin
    wr.en = (state_r == S_DONE) && out_free && wb_r;
    wr.idx = idx_r;
    wr.key = key_r;
    wr.fails = fails_r;
    wr.wait_until = wait_r;
    wr.last = last_r;
    wr.told = told_r;
  end

  assign quiet = {1'b0, now_r} - {1'b0, tail.last};
  assign forget_hit = !quiet[TIME_W] && (quiet[TIME_W-1:0] > {21'b0, forget_r});
  assign wdiff = wait_r - now_r;
  assign gap = {1'b0, now_r} - {1'b0, anchor_r};
  assign due = (tokens_r < bucket_r) && !gap[TIME_W] &&
               (gap[TIME_W-1:0] >= {21'b0, period_r});
  assign fails_inc = (fails_r == FAIL_MAX) ? fails_r : fails_r + 16'd1;
  assign wait_cl = (dbl_r > {1'b0, max_r}) ? max_r : dbl_r[MS_W-1:0];
  assign end_sum = {1'b0, now_r} + {22'b0, wait_cl};
  assign wait_end = end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0];
  assign dbl_go = (cnt_r != '0) && (dbl_r < {1'b0, max_r}) && (dbl_r != '0);
  assign prod_nxt = {28'b0, x_r} * {27'b0, RECIP_1000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= 8'd3;
      first_r <= 27'd1000;
      max_r <= 27'd60000;
      bucket_r <= 8'd10;
      period_r <= 27'd1000;
      forget_r <= 27'd3600000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FREE_TRIES: free_r <= cfg_wdata[7:0];
        REG_FIRST_DELAY: first_r <= cfg_wdata;
        REG_MAX_DELAY: max_r <= cfg_wdata;
        REG_BUCKET_SIZE: bucket_r <= cfg_wdata[7:0];
        REG_REFILL_PERIOD: period_r <= cfg_wdata;
        REG_FORGET_AFTER: forget_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      tokens_r <= 8'd10;
      anchor_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !(state_r == S_DONE && out_free)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r <= in_opcode;
            key_r <= in_source_key;
            now_r <= in_now_ms;
            res_allowed_r <= 1'b0;
            res_retry_r <= '0;
            res_first_r <= 1'b0;
            wb_r <= (in_opcode != OP_NOP);
            state_r <= (in_opcode == OP_NOP) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (tail.vld) begin
            idx_r <= tail.hit ? tail.idx : tail.pick;
            if (tail.hit && !forget_hit) begin
              fails_r <= tail.fails;
              wait_r <= tail.wait_until;
              told_r <= tail.told;
            end else begin
              fails_r <= '0;
              wait_r <= '0;
              told_r <= 1'b0;
            end
            last_r <= tail.hit ? tail.last : '0;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (op_r)
            OP_QUERY: begin
              last_r <= now_r;
              if (wait_r > now_r) begin
                res_first_r <= !told_r;
                told_r <= 1'b1;
                if (wdiff > RETRY_MAX_MS) begin
                  res_retry_r <= RETRY_MAX;
                  state_r <= S_DONE;
                end else begin
                  x_r <= wdiff[MS_W-1:0] + ROUND_UP;
                  state_r <= S_MUL;
                end
              end else begin
                if (anchor_r == '0) begin
                  anchor_r <= now_r;
                end
                state_r <= S_REFILL;
              end
            end
            OP_FAIL: begin
              fails_r <= fails_inc;
              if (fails_inc > {8'b0, free_r}) begin
                dbl_r <= {1'b0, first_r};
                cnt_r <= fails_inc - {8'b0, free_r} - 16'd1;
                state_r <= S_BACKOFF;
              end else begin
                state_r <= S_DONE;
              end
            end
            default: begin
              fails_r <= '0;
              wait_r <= '0;
              told_r <= 1'b0;
              if (tokens_r < bucket_r) begin
                tokens_r <= tokens_r + 8'd1;
              end
              state_r <= S_DONE;
            end
          endcase
        end
        S_MUL: begin
          state_r <= S_QUOT;
        end
        S_QUOT: begin
          res_retry_r <= prod_r[RECIP_SHIFT+RETRY_W-1:RECIP_SHIFT];
          state_r <= S_DONE;
        end
        S_REFILL: begin
          if (due) begin
            tokens_r <= tokens_r + 8'd1;
            anchor_r <= anchor_r + {21'b0, period_r};
          end else begin
            if (tokens_r >= bucket_r || anchor_r > now_r) begin
              anchor_r <= now_r;
            end
            if (tokens_r == '0) begin
              res_retry_r <= 17'd1;
            end else begin
              tokens_r <= tokens_r - 8'd1;
              res_allowed_r <= 1'b1;
            end
            state_r <= S_DONE;
          end
        end
        S_BACKOFF: begin
          if (dbl_go) begin
            dbl_r <= {dbl_r[MS_W-1:0], 1'b0};
            cnt_r <= cnt_r - 16'd1;
          end else begin
            wait_r <= wait_end;
            told_r <= 1'b0;
            state_r <= S_DONE;
          end
        end
        default: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_allowed_r <= res_allowed_r;
            out_retry_r <= res_retry_r;
            out_first_r <= res_first_r;
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_allowed = out_allowed_r;
  assign out_retry_seconds = out_retry_r;
  assign out_first_refusal = out_first_r;

  a_allowed_no_retry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_allowed_r |-> out_retry_r == '0)
    else $error("allowed result carries a retry time");

  a_first_is_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_first_r |-> !out_allowed_r && out_retry_r != '0)
    else $error("first refusal flagged on a result that is not a timed refusal");

  a_probe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |-> state_r == S_SCAN)
    else $error("lookup probe left the slot row outside the scan step");

  a_write_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> state_r == S_IDLE && out_valid_r)
    else $error("slot write back not followed by a delivered result");

endmodule
